FILE: rtl/dns_pkg.sv
// Shared types, constants and helpers for the decimal number scanner.
package dns_pkg;

    localparam int FRAC_DIGITS = 6;
    localparam int FRAC_BITS   = 16;
    localparam int INT_W       = 16;
    localparam int FRAC_W      = 20;
    localparam int CNT_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int INT_LIMIT   = 65535;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_DOT   = 8'd46;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Fraction is held left-aligned to FRAC_DIGITS digits, so the rounded
    // binary fraction is floor((frac * 2^10 + 7812) / 15625), since
    // 10^6 = 2^6 * 15625. The divide is a reciprocal multiply, exact for
    // numerators below 2^30.
    localparam int FRAC_SHIFT  = FRAC_BITS - FRAC_DIGITS;
    localparam int ROUND_W     = FRAC_W + FRAC_SHIFT;
    localparam logic [ROUND_W-1:0] ROUND_BIAS = 30'd7812;
    localparam int RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP = 31'd1125899907;
    localparam int RECIP_SHIFT = 44;
    localparam int PROD_W      = ROUND_W + RECIP_W;
    localparam int QUOT_W      = 17;

    typedef struct packed {
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_part;
        logic              neg;
        logic              ovf;
        logic              eol;
    } num_snap_t;

    typedef struct packed {
        logic in_number;
        logic in_fraction;
    } scan_stat_t;

    // Weight of a fraction digit at a given position after the dot.
    function automatic logic [FRAC_W-1:0] digit_weight(input logic [CNT_W-1:0] pos);
        logic [FRAC_W-1:0] w;
        unique case (pos)
            3'd0:    w = 20'd100000;
            3'd1:    w = 20'd10000;
            3'd2:    w = 20'd1000;
            3'd3:    w = 20'd100;
            3'd4:    w = 20'd10;
            default: w = 20'd1;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/dns_scan.sv
// Character scanner: number state update per item and snapshot of closed numbers.
module dns_scan
    import dns_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // text_byte
    input  logic [0:0] s_tuser,    // skip_byte
    input  logic       s_tlast,    // end_of_line
    output num_snap_t  snap,
    output logic       snap_valid,
    input  logic       snap_ready,
    output scan_stat_t stat
);

    logic [INT_W-1:0]  int_reg, int_next, a_int;
    logic [FRAC_W-1:0] frac_reg, frac_next, a_frac;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, a_cnt;
    logic neg_reg, neg_next, a_neg;
    logic in_num_reg, in_num_next, a_in_num;
    logic in_frac_reg, in_frac_next, a_in_frac;
    logic ovf_reg, ovf_next, a_ovf;
    num_snap_t snap_reg, snap_next;
    logic snap_valid_reg;

    logic              accept, is_digit, emit_char, emit_eol;
    logic [7:0]        digit_full;
    logic [3:0]        digit;
    logic [INT_W+3:0]  int_ext, int_mul;
    logic [FRAC_W+3:0] frac_prod;
    logic [FRAC_W-1:0] frac_sum;

    assign s_tready   = !snap_valid_reg || snap_ready;
    assign accept     = s_tvalid && s_tready;
    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;
    assign stat       = '{in_number: in_num_reg, in_fraction: in_frac_reg};

    assign is_digit   = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign digit_full = s_tdata - CHAR_ZERO;
    assign digit      = digit_full[3:0];
    assign int_ext    = {4'b0, int_reg};
    assign int_mul    = (int_ext << 3) + (int_ext << 1) + {{INT_W{1'b0}}, digit};
    assign frac_prod  = digit * digit_weight(cnt_reg);
    assign frac_sum   = frac_reg + frac_prod[FRAC_W-1:0];

    always_comb begin
        a_int     = int_reg;
        a_frac    = frac_reg;
        a_cnt     = cnt_reg;
        a_neg     = neg_reg;
        a_in_num  = in_num_reg;
        a_in_frac = in_frac_reg;
        a_ovf     = ovf_reg;
        emit_char = 1'b0;
        if (!s_tuser[0]) begin
            if (is_digit) begin
                a_in_num = 1'b1;
                if (in_frac_reg) begin
                    if (cnt_reg < CNT_W'(FRAC_DIGITS)) begin
                        a_frac = frac_sum;
                        a_cnt  = cnt_reg + 1'b1;
                    end
                end else if (int_mul > (INT_W+4)'(INT_LIMIT)) begin
                    a_int = INT_W'(INT_LIMIT);
                    a_ovf = 1'b1;
                end else begin
                    a_int = int_mul[INT_W-1:0];
                end
            end else if (s_tdata == CHAR_DOT && in_num_reg && !in_frac_reg) begin
                a_in_frac = 1'b1;
            end else begin
                if (in_num_reg) begin
                    emit_char = 1'b1;
                    a_int     = '0;
                    a_frac    = '0;
                    a_cnt     = '0;
                    a_neg     = 1'b0;
                    a_in_num  = 1'b0;
                    a_in_frac = 1'b0;
                    a_ovf     = 1'b0;
                end
                if (s_tdata == CHAR_MINUS) begin
                    a_neg = 1'b1;
                end
            end
        end

        emit_eol = s_tlast && a_in_num;

        if (emit_char) begin
            snap_next = '{int_part: int_reg, frac_part: frac_reg, neg: neg_reg,
                          ovf: ovf_reg, eol: 1'b0};
        end else begin
            snap_next = '{int_part: a_int, frac_part: a_frac, neg: a_neg,
                          ovf: a_ovf, eol: 1'b1};
        end

        if (s_tlast) begin
            int_next     = '0;
            frac_next    = '0;
            cnt_next     = '0;
            neg_next     = 1'b0;
            in_num_next  = 1'b0;
            in_frac_next = 1'b0;
            ovf_next     = 1'b0;
        end else begin
            int_next     = a_int;
            frac_next    = a_frac;
            cnt_next     = a_cnt;
            neg_next     = a_neg;
            in_num_next  = a_in_num;
            in_frac_next = a_in_frac;
            ovf_next     = a_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_reg        <= '0;
            frac_reg       <= '0;
            cnt_reg        <= '0;
            neg_reg        <= 1'b0;
            in_num_reg     <= 1'b0;
            in_frac_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                int_reg     <= int_next;
                frac_reg    <= frac_next;
                cnt_reg     <= cnt_next;
                neg_reg     <= neg_next;
                in_num_reg  <= in_num_next;
                in_frac_reg <= in_frac_next;
                ovf_reg     <= ovf_next;
            end
            if (s_tready) begin
                snap_valid_reg <= accept && (emit_char || emit_eol);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (emit_char || emit_eol)) begin
            snap_reg <= snap_next;
        end
    end

endmodule

FILE: rtl/dns_conv.sv
// Fixed-point conversion: fraction rounding multiply, then sum, saturation and sign.
module dns_conv
    import dns_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  num_snap_t                 snap,
    input  logic                      snap_valid,
    output logic                      snap_ready,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic signed [VALUE_W-1:0] m_tdata,   // number_value
    output logic                      m_tlast    // ended_by_line_end
);

    logic              s1_valid_reg;
    logic [INT_W-1:0]  s1_int_reg;
    logic [QUOT_W-1:0] s1_quot_reg;
    logic              s1_neg_reg, s1_ovf_reg, s1_eol_reg;
    logic              out_valid_reg, out_last_reg;
    logic [VALUE_W-1:0] out_data_reg, out_data_next;

    logic               out_free, s1_ready;
    logic [ROUND_W-1:0] round_num;
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W:0]   mag, limit, sat;
    logic [VALUE_W-1:0] word;

    assign out_free   = !out_valid_reg || m_tready;
    assign s1_ready   = !s1_valid_reg || out_free;
    assign snap_ready = s1_ready;

    assign round_num = {snap.frac_part, {FRAC_SHIFT{1'b0}}} + ROUND_BIAS;
    assign prod      = PROD_W'(round_num) * PROD_W'(RECIP);

    always_comb begin
        mag   = {1'b0, s1_int_reg, {FRAC_BITS{1'b0}}} + (VALUE_W+1)'(s1_quot_reg);
        limit = s1_neg_reg ? {2'b01, {(VALUE_W-1){1'b0}}} : {2'b00, {(VALUE_W-1){1'b1}}};
        sat   = (s1_ovf_reg || mag > limit) ? limit : mag;
        word  = sat[VALUE_W-1:0];
        out_data_next = s1_neg_reg ? (~word + 1'b1) : word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= snap_valid;
            end
            if (out_free) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && snap_valid) begin
            s1_int_reg  <= snap.int_part;
            s1_quot_reg <= prod[RECIP_SHIFT +: QUOT_W];
            s1_neg_reg  <= snap.neg;
            s1_ovf_reg  <= snap.ovf;
            s1_eol_reg  <= snap.eol;
        end
        if (out_free && s1_valid_reg) begin
            out_data_reg <= out_data_next;
            out_last_reg <= s1_eol_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/decimal_number_scanner_core.sv
// Top level of the decimal number scanner: scanner plus conversion pipeline.
// Throughput: one item per cycle while s_tready is high; the scanner state
// updates in the accept cycle. A closed number passes the snapshot register,
// the reciprocal multiply stage and the output register before m_tvalid.
// Reset: synchronous active-low aresetn clears the scan state and all valid bits.
module decimal_number_scanner_core
    import dns_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // text_byte
    input  logic [0:0]                s_tuser,   // skip_byte
    input  logic                      s_tlast,   // end_of_line
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic signed [VALUE_W-1:0] m_tdata,   // number_value
    output logic                      m_tlast    // ended_by_line_end
);

    num_snap_t  snap;
    logic       snap_valid, snap_ready;
    scan_stat_t stat;

    dns_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .stat       (stat)
    );

    dns_conv u_conv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_line_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !stat.in_number && !stat.in_fraction)
        else $error("scan state not cleared after line end");

    a_fraction_in_number: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.in_fraction |-> stat.in_number)
        else $error("fraction active without a number");

    a_snap_held: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_valid && !snap_ready |=> snap_valid && $stable(snap))
        else $error("stalled snapshot lost or changed");

    a_snap_eol_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> !(snap_valid && $changed(snap) && snap.eol))
        else $error("line-end tag on a number closed by a character");

endmodule
